// File: src/crcfp_pkg.sv
// crcfp_pkg: types, constants and CRC helpers for the CRC-16 frame parser.
// Used by crc16_frame_parser; depends on nothing else.
`default_nettype none

package crcfp_pkg;

    localparam int unsigned MAX_PAYLOAD = 64;   // largest accepted payload length
    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned STORE_AW    = 6;
    localparam int unsigned LEN_W       = 7;    // holds 0..MAX_PAYLOAD

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
    localparam logic [15:0] CRC_SEED_RST    = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_FEED    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_SYNC_FIRST  = 2'd0,
        REG_SYNC_SECOND = 2'd1,
        REG_CRC_SEED    = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    typedef enum logic [6:0] {
        PH_SYNC1 = 7'b000_0001,
        PH_SYNC2 = 7'b000_0010,
        PH_ID    = 7'b000_0100,
        PH_LEN   = 7'b000_1000,
        PH_DATA  = 7'b001_0000,
        PH_CRCLO = 7'b010_0000,
        PH_CRCHI = 7'b100_0000
    } phase_t;

    // CRC-16, MSB first, one byte: eight shift/xor steps on 16 bits
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] cnt);
        return (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
    endfunction

endpackage

`default_nettype wire

// File: src/crc16_frame_parser.sv
// crc16_frame_parser: byte-serial sync/length/CRC-16 frame receiver with a
// 64-entry payload memory. Depends on crcfp_pkg.
//
// Usage
//   s_ channel: one item per command. s_tuser = command (feed, restart hunt,
//   clear counters, read payload entry); s_tdata carries the stream byte and
//   the payload read index.
//   m_ channel: exactly one result item per input item, in order. m_tuser
//   flags a fed byte that closed a frame with a good CRC; m_tdata carries the
//   header fields, the payload read data and the four saturating counters.
//   cfg_ channel: register writes (sync bytes, CRC seed), always ready; write
//   only while no item is in flight.
// Latency and throughput
//   The result of an item is valid the cycle after it is accepted. One item
//   per cycle while m_tready is high: the header/CRC next state is combinational
//   and the payload memory is read and written through one synchronous port each.
// Reset and stall
//   aresetn (synchronous, low) returns the parser to sync hunt, zeroes the
//   counters and held header, and restores the register defaults. The payload
//   memory is not cleared. When m_tready is low, the single output stage holds
//   and s_tready drops until the pending result is taken.
`default_nettype none

module crc16_frame_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [13:8] read_index, [15:14] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] frame_id, [14:8] frame_len, [22:15] read_data,
    // [38:23] frame_count, [54:39] bad_crc_count, [70:55] resync_count,
    // [86:71] bad_length_count, [87] zero
    output logic [87:0]      m_tdata,
    output logic             m_tuser,   // [0] frame_good
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import crcfp_pkg::*;

    // ---------------- input unpack ----------------
    logic                in_accept;
    cmd_t                cmd;
    logic [7:0]          in_byte;
    logic [STORE_AW-1:0] in_read_idx;

    assign cmd         = cmd_t'(s_tuser);
    assign in_byte     = s_tdata[7:0];
    assign in_read_idx = s_tdata[13:8];

    // ---------------- configuration ----------------
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [15:0] crc_seed_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            crc_seed_reg    <= CRC_SEED_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                REG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                REG_CRC_SEED:    crc_seed_reg    <= cfg_data;
                REG_UNUSED:      ;
            endcase
        end
    end

    // ---------------- parser state ----------------
    phase_t           phase_reg, phase_next;
    logic [7:0]       held_id_reg, held_id_next;
    logic [LEN_W-1:0] held_len_reg, held_len_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic [15:0]      good_cnt_reg, good_cnt_next;
    logic [15:0]      crcerr_cnt_reg, crcerr_cnt_next;
    logic [15:0]      resync_cnt_reg, resync_cnt_next;
    logic [15:0]      lenerr_cnt_reg, lenerr_cnt_next;
    logic             good_next;
    logic             mem_we;

    // shared CRC step: seed on the id byte, running value otherwise
    logic [15:0] crc_base;
    logic [15:0] crc_step;
    logic [LEN_W-1:0] fill_inc;

    assign crc_base = (phase_reg == PH_ID) ? crc_seed_reg : crc_reg;
    assign crc_step = crc16_byte(crc_base, in_byte);
    assign fill_inc = fill_reg + 1'b1;

    always_comb begin
        phase_next      = phase_reg;
        held_id_next    = held_id_reg;
        held_len_next   = held_len_reg;
        fill_next       = fill_reg;
        crc_next        = crc_reg;
        crc_lo_next     = crc_lo_reg;
        good_cnt_next   = good_cnt_reg;
        crcerr_cnt_next = crcerr_cnt_reg;
        resync_cnt_next = resync_cnt_reg;
        lenerr_cnt_next = lenerr_cnt_reg;
        good_next       = 1'b0;
        mem_we          = 1'b0;

        unique case (cmd)
            CMD_FEED: begin
                unique case (phase_reg)
                    PH_SYNC1: begin
                        if (in_byte == sync_first_reg) begin
                            phase_next = PH_SYNC2;
                        end else begin
                            resync_cnt_next = sat_inc(resync_cnt_reg);
                        end
                    end
                    PH_SYNC2: begin
                        // second sync wins over a repeated first sync
                        if (in_byte == sync_second_reg) begin
                            phase_next = PH_ID;
                        end else begin
                            resync_cnt_next = sat_inc(resync_cnt_reg);
                            if (in_byte != sync_first_reg) begin
                                phase_next = PH_SYNC1;
                            end
                        end
                    end
                    PH_ID: begin
                        held_id_next = in_byte;
                        crc_next     = crc_step;
                        phase_next   = PH_LEN;
                    end
                    PH_LEN: begin
                        if (in_byte > 8'(MAX_PAYLOAD)) begin
                            lenerr_cnt_next = sat_inc(lenerr_cnt_reg);
                            phase_next      = PH_SYNC1;
                            fill_next       = '0;
                        end else begin
                            held_len_next = in_byte[LEN_W-1:0];
                            fill_next     = '0;
                            crc_next      = crc_step;
                            phase_next    = (in_byte == 8'h00) ? PH_CRCLO : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        mem_we    = 1'b1;
                        crc_next  = crc_step;
                        fill_next = fill_inc;
                        if (fill_inc >= held_len_reg) begin
                            phase_next = PH_CRCLO;
                        end
                    end
                    PH_CRCLO: begin
                        crc_lo_next = in_byte;
                        phase_next  = PH_CRCHI;
                    end
                    PH_CRCHI: begin
                        phase_next = PH_SYNC1;
                        fill_next  = '0;
                        if ({in_byte, crc_lo_reg} == crc_reg) begin
                            good_cnt_next = sat_inc(good_cnt_reg);
                            good_next     = 1'b1;
                        end else begin
                            crcerr_cnt_next = sat_inc(crcerr_cnt_reg);
                        end
                    end
                    default: begin
                        // illegal phase code: back to hunt, byte dropped
                        phase_next = PH_SYNC1;
                        fill_next  = '0;
                    end
                endcase
            end
            CMD_RESTART: begin
                phase_next = PH_SYNC1;
                fill_next  = '0;
            end
            CMD_CLEAR: begin
                good_cnt_next   = '0;
                crcerr_cnt_next = '0;
                resync_cnt_next = '0;
                lenerr_cnt_next = '0;
            end
            CMD_READ: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SYNC1;
            held_id_reg    <= '0;
            held_len_reg   <= '0;
            fill_reg       <= '0;
            crc_reg        <= CRC_SEED_RST;
            crc_lo_reg     <= '0;
            good_cnt_reg   <= '0;
            crcerr_cnt_reg <= '0;
            resync_cnt_reg <= '0;
            lenerr_cnt_reg <= '0;
        end else if (in_accept) begin
            phase_reg      <= phase_next;
            held_id_reg    <= held_id_next;
            held_len_reg   <= held_len_next;
            fill_reg       <= fill_next;
            crc_reg        <= crc_next;
            crc_lo_reg     <= crc_lo_next;
            good_cnt_reg   <= good_cnt_next;
            crcerr_cnt_reg <= crcerr_cnt_next;
            resync_cnt_reg <= resync_cnt_next;
            lenerr_cnt_reg <= lenerr_cnt_next;
        end
    end

    // ---------------- payload memory ----------------
    // One write (payload fill) and one registered read (read command) per
    // cycle, on accepted items only. A read always sees the writes of earlier items.
    logic [7:0] store_mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (in_accept && mem_we) begin
            store_mem[fill_reg[STORE_AW-1:0]] <= in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_data_reg <= store_mem[in_read_idx];
        end
    end

    // ---------------- output stage ----------------
    // Header and counter fields come straight from the state registers; they
    // only change on an accept, which cannot happen while a result waits.
    logic m_valid_reg;
    logic good_reg;
    logic rd_sel_reg;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            good_reg    <= 1'b0;
            rd_sel_reg  <= 1'b0;
        end else begin
            if (in_accept) begin
                m_valid_reg <= 1'b1;
                good_reg    <= good_next;
                rd_sel_reg  <= (cmd == CMD_READ);
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    logic [7:0] rd_out;
    assign rd_out = rd_sel_reg ? rd_data_reg : 8'h00;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = good_reg;
    assign m_tdata  = {1'b0, lenerr_cnt_reg, resync_cnt_reg, crcerr_cnt_reg,
                       good_cnt_reg, rd_out, held_len_reg, held_id_reg};

endmodule

`default_nettype wire

// File: sim/crc16_frame_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for crc16_frame_parser: sync hunt, header checks, CRC-16 frames,
// payload reads and the saturating counters, under several sync/seed settings and flow mixes.
// Depends on crcfp_pkg and crc16_frame_parser (src/).

import crcfp_pkg::*;

// One result item, unpacked from m_tuser / m_tdata
typedef struct {
    logic        frame_good;
    logic [7:0]  frame_id;
    logic [6:0]  frame_len;
    logic [7:0]  read_data;
    logic [15:0] frame_count;
    logic [15:0] bad_crc_count;
    logic [15:0] resync_count;
    logic [15:0] bad_length_count;
} parser_out_t;

class frame_scoreboard;
    // register copies
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    logic [15:0] seed;
    // parser state
    phase_t      phase;
    logic [7:0]  hdr_id;
    logic [6:0]  hdr_len;
    logic [6:0]  fill;
    logic [7:0]  payload_mem [STORE_DEPTH];
    logic [63:0] written;        // entries that hold a fed byte
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    logic [15:0] n_good;
    logic [15:0] n_badcrc;
    logic [15:0] n_resync;
    logic [15:0] n_badlen;
    parser_out_t pending_results [$];
    // run statistics, never cleared
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned tot_good;
    int unsigned tot_badcrc;
    int unsigned tot_badlen;
    int unsigned tot_reads;

    function new();
        sync_a   = SYNC_FIRST_RST;
        sync_b   = SYNC_SECOND_RST;
        seed     = CRC_SEED_RST;
        phase    = PH_SYNC1;
        hdr_id   = '0;
        hdr_len  = '0;
        fill     = '0;
        written  = '0;
        crc_acc  = CRC_SEED_RST;
        crc_lo   = '0;
        n_good   = '0;
        n_badcrc = '0;
        n_resync = '0;
        n_badlen = '0;
        mismatches   = 0;
        results_seen = 0;
        tot_good     = 0;
        tot_badcrc   = 0;
        tot_badlen   = 0;
        tot_reads    = 0;
    endfunction

    // CRC-16/0x1021, MSB first, one data bit per step
    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb) r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    static function logic [15:0] sat_up(logic [15:0] c);
        if (&c) return c;
        return c + 16'd1;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] v);
        case (idx)
            REG_SYNC_FIRST:  sync_a = v[7:0];
            REG_SYNC_SECOND: sync_b = v[7:0];
            REG_CRC_SEED:    seed   = v;
            default: ;
        endcase
    endfunction

    // one fed byte through the parser; returns 1 when it closes a good frame
    function bit parse_byte(logic [7:0] b);
        bit good;
        good = 1'b0;
        case (phase)
            PH_SYNC1: begin
                if (b == sync_a) phase = PH_SYNC2;
                else n_resync = sat_up(n_resync);
            end
            PH_SYNC2: begin
                // second sync wins over a repeated first sync
                if (b == sync_b) begin
                    phase = PH_ID;
                end else begin
                    n_resync = sat_up(n_resync);
                    if (b != sync_a) phase = PH_SYNC1;
                end
            end
            PH_ID: begin
                hdr_id  = b;
                crc_acc = crc_step(seed, b);
                phase   = PH_LEN;
            end
            PH_LEN: begin
                if (b > MAX_PAYLOAD) begin
                    n_badlen = sat_up(n_badlen);
                    tot_badlen++;
                    phase = PH_SYNC1;
                    fill  = '0;
                end else begin
                    hdr_len = b[6:0];
                    fill    = '0;
                    crc_acc = crc_step(crc_acc, b);
                    phase   = (b == 8'd0) ? PH_CRCLO : PH_DATA;
                end
            end
            PH_DATA: begin
                payload_mem[fill[5:0]] = b;
                written[fill[5:0]]     = 1'b1;
                crc_acc = crc_step(crc_acc, b);
                fill    = fill + 7'd1;
                if (fill >= hdr_len) phase = PH_CRCLO;
            end
            PH_CRCLO: begin
                crc_lo = b;
                phase  = PH_CRCHI;
            end
            PH_CRCHI: begin
                phase = PH_SYNC1;
                fill  = '0;
                if ({b, crc_lo} == crc_acc) begin
                    n_good = sat_up(n_good);
                    tot_good++;
                    good = 1'b1;
                end else begin
                    n_badcrc = sat_up(n_badcrc);
                    tot_badcrc++;
                end
            end
            default: begin
                phase = PH_SYNC1;
                fill  = '0;
            end
        endcase
        return good;
    endfunction

    // accepted input item -> expected result item
    function void predict_item(cmd_t cmd, logic [7:0] b, logic [5:0] idx);
        parser_out_t e;
        e.frame_good = 1'b0;
        e.read_data  = '0;
        case (cmd)
            CMD_FEED:    e.frame_good = parse_byte(b);
            CMD_RESTART: begin
                phase = PH_SYNC1;
                fill  = '0;
            end
            CMD_CLEAR: begin
                n_good   = '0;
                n_badcrc = '0;
                n_resync = '0;
                n_badlen = '0;
            end
            default: begin
                e.read_data = payload_mem[idx];
                tot_reads++;
            end
        endcase
        e.frame_id         = hdr_id;
        e.frame_len        = hdr_len;
        e.frame_count      = n_good;
        e.bad_crc_count    = n_badcrc;
        e.resync_count     = n_resync;
        e.bad_length_count = n_badlen;
        pending_results.push_back(e);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] mismatch %s at result %0d: got %h, expected %h",
                     $realtime, what, results_seen, got, want);
    endtask

    task check_item(logic flag, logic [87:0] d);
        parser_out_t g;
        parser_out_t w;
        results_seen++;
        if (pending_results.size() == 0) begin
            report("result with nothing pending", 16'(flag), 16'h0);
            return;
        end
        w = pending_results.pop_front();
        g.frame_good       = flag;
        g.frame_id         = d[7:0];
        g.frame_len        = d[14:8];
        g.read_data        = d[22:15];
        g.frame_count      = d[38:23];
        g.bad_crc_count    = d[54:39];
        g.resync_count     = d[70:55];
        g.bad_length_count = d[86:71];
        if (g.frame_good !== w.frame_good)
            report("frame_good", 16'(g.frame_good), 16'(w.frame_good));
        if (g.frame_id !== w.frame_id)
            report("frame_id", 16'(g.frame_id), 16'(w.frame_id));
        if (g.frame_len !== w.frame_len)
            report("frame_len", 16'(g.frame_len), 16'(w.frame_len));
        if (g.read_data !== w.read_data)
            report("read_data", 16'(g.read_data), 16'(w.read_data));
        if (g.frame_count !== w.frame_count)
            report("frame_count", g.frame_count, w.frame_count);
        if (g.bad_crc_count !== w.bad_crc_count)
            report("bad_crc_count", g.bad_crc_count, w.bad_crc_count);
        if (g.resync_count !== w.resync_count)
            report("resync_count", g.resync_count, w.resync_count);
        if (g.bad_length_count !== w.bad_length_count)
            report("bad_length_count", g.bad_length_count, w.bad_length_count);
    endtask
endclass

module crc16_frame_parser_tb;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;          // [7:0] data_byte, [13:8] read_index, [15:14] zero
    logic [1:0]  s_tuser   = CMD_FEED;    // [1:0] command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;                 // header, read data, four counters (see DUT)
    logic        m_tuser;                 // [0] frame_good
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_SYNC_FIRST;
    logic [15:0] cfg_data  = '0;

    // flow-control mix, percent of cycles
    int unsigned src_idle_pct = 0;
    int unsigned stall_pct    = 0;
    int unsigned items_sent   = 0;
    int unsigned n_settings   = 1;
    bit          mix_reads    = 1'b0;     // sprinkle payload reads into frames

    frame_scoreboard sb = new();

    always #1 aclk = ~aclk;

    crc16_frame_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Receiver: random backpressure, changed at the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Result monitor: sample at the rising edge, compare with oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_item(m_tuser, m_tdata);
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // One input item; optional idle gap first, then hold until accepted
    task automatic send_item(cmd_t cmd, logic [7:0] b, logic [5:0] idx);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx, b};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        sb.predict_item(cmd, b, idx);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(CMD_FEED, b, 6'($urandom_range(63)));
    endtask

    task automatic send_cmd(cmd_t cmd);
        send_item(cmd, 8'($urandom_range(255)), 6'($urandom_range(63)));
    endtask

    // Read a payload entry that has been written at least once
    task automatic send_read();
        logic [5:0] idx;
        if (sb.written == '0) return;
        do idx = 6'($urandom_range(63)); while (!sb.written[idx]);
        send_item(CMD_READ, 8'($urandom_range(255)), idx);
    endtask

    // Full frame: [extra first sync] sync sync id len payload crc_lo crc_hi.
    // An oversize length ends the frame after the length byte. A nonzero cut
    // replaces byte number cut with a restart command and drops the rest.
    task automatic send_frame(logic [7:0] id, int unsigned len, bit extra_sync,
                              bit bad_crc, int unsigned cut);
        logic [7:0]  seq [$];
        logic [15:0] c;
        int unsigned k;
        if (extra_sync) seq.push_back(sb.sync_a);
        seq.push_back(sb.sync_a);
        seq.push_back(sb.sync_b);
        seq.push_back(id);
        seq.push_back(8'(len));
        c = sb.crc_step(sb.crc_step(sb.seed, id), 8'(len));
        if (len <= MAX_PAYLOAD) begin
            for (k = 0; k < len; k++) begin
                seq.push_back(8'($urandom_range(255)));
                c = sb.crc_step(c, seq[$]);
            end
            if (bad_crc) c = c ^ 16'($urandom_range(1, 65535));
            seq.push_back(c[7:0]);          // CRC goes low byte first
            seq.push_back(c[15:8]);
        end
        for (k = 0; k < seq.size(); k++) begin
            if (cut != 0 && k == cut) begin
                send_cmd(CMD_RESTART);
                return;
            end
            if (mix_reads && $urandom_range(99) < 4) send_read();
            send_byte(seq[k]);
        end
    endtask

    // Mostly small frames, some full-size ones, a few oversize headers
    task automatic send_random_frame();
        int unsigned r;
        int unsigned len;
        int unsigned cut;
        r = $urandom_range(99);
        if (r < 5)       len = $urandom_range(MAX_PAYLOAD + 1, 255);
        else if (r < 60) len = $urandom_range(8);
        else if (r < 88) len = $urandom_range(9, MAX_PAYLOAD - 1);
        else             len = MAX_PAYLOAD;
        cut = 0;
        if ($urandom_range(99) < 5)
            cut = $urandom_range(1, 3 + ((len <= MAX_PAYLOAD) ? len : 0));
        send_frame(8'($urandom_range(255)), len, $urandom_range(9) == 0,
                   $urandom_range(99) < 15, cut);
    endtask

    // Frames with random content, plus line noise and loose commands
    task automatic random_traffic(int unsigned n);
        int unsigned stop_at;
        int unsigned r;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 6) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end else if (r < 10) begin
                send_cmd(CMD_RESTART);
            end else if (r < 12) begin
                send_cmd(CMD_CLEAR);
            end else if (r < 20) begin
                send_read();
            end else begin
                send_random_frame();
            end
        end
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, v);
        @(negedge aclk);
    endtask

    // Unused upper bits of the sync writes carry noise; the block drops them
    task automatic apply_setting(logic [7:0] a, logic [7:0] b, logic [15:0] seed,
                                 bit poke_unused);
        write_reg(REG_SYNC_FIRST, {8'($urandom_range(255)), a});
        write_reg(REG_SYNC_SECOND, {8'($urandom_range(255)), b});
        write_reg(REG_CRC_SEED, seed);
        if (poke_unused) write_reg(REG_UNUSED, 16'($urandom_range(65535)));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Stop sending and let every predicted result come out, then wait out
    // the registered output stage
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned src_mix  [4];
        int unsigned sink_mix [4];
        src_mix  = '{0, 50, 0, 7};
        sink_mix = '{0, 0, 50, 7};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset settings (first sync 0xAA, second 0x55, seed 0xFFFF)
        send_byte(SYNC_FIRST_RST);
        send_byte(8'h33);                      // wrong byte after first sync
        send_frame(8'hFF, 0, 1'b1, 1'b0, 0);   // repeated first sync, empty payload
        send_frame(8'h5A, 1, 1'b0, 1'b0, 0);   // one payload byte, good CRC
        send_item(CMD_READ, 8'h00, 6'd0);
        send_frame(8'h7F, MAX_PAYLOAD + 1, 1'b0, 1'b0, 0);  // oversize length
        send_frame(8'h11, 3, 1'b0, 1'b0, 1);   // restart right after first sync
        send_cmd(CMD_CLEAR);
        send_frame(8'h00, 0, 1'b0, 1'b1, 0);   // CRC mismatch

        // Random part: five register settings, each under four flow mixes
        mix_reads = 1'b1;
        for (int s = 0; s < 5; s++) begin
            if (s > 0) begin
                drain();
                case (s)
                    1: apply_setting(8'h00, 8'hFF, 16'h0000, 1'b0);
                    2: apply_setting(8'hFF, 8'h00, 16'hFFFF, 1'b0);
                    // equal sync bytes: second-sync match wins
                    3: apply_setting(8'h7E, 8'h7E, 16'($urandom_range(65535)), 1'b0);
                    default: apply_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                                           16'($urandom_range(65535)), 1'b1);
                endcase
            end
            for (int m = 0; m < 4; m++) begin
                src_idle_pct = src_mix[m];
                stall_pct    = sink_mix[m];
                random_traffic(55);
            end
        end

        drain();
        if (sb.pending_results.size() != 0)
            sb.report("results never delivered", 16'(sb.pending_results.size()), 16'h0);

        $display("Covered %0d items over %0d register settings and 4 flow mixes.",
                 items_sent, n_settings);
        $display("Frames: %0d good, %0d bad CRC, %0d oversize headers; %0d payload reads.",
                 sb.tot_good, sb.tot_badcrc, sb.tot_badlen, sb.tot_reads);
        if (sb.mismatches == 0) begin
            $display("** crc16_frame_parser: PASSED **");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("** crc16_frame_parser: FAILED **");
        end
        $finish;
    end

    // Watchdog: far above the slowest legal run
    initial begin
        #400_000;
        $display("Timeout with %0d results outstanding", sb.pending_results.size());
        $display("** crc16_frame_parser: FAILED **");
        $finish;
    end

endmodule
